/* design/fdc_pkg.sv */
// Shared types, constants and the CRC-16/XMODEM byte step for the frame deframer.
// Used by fdc_cfg_regs, fdc_step and frame_deframer_crc16_check_unit.
// No dependencies.
package fdc_pkg;

  localparam int HEADER_BYTES = 9;
  localparam int TAIL_BYTES   = 4;

  // Byte positions within the little-endian header.
  localparam logic [15:0] HDR_TYPE_POS  = 16'd4;
  localparam logic [15:0] HDR_LEN_LO    = 16'd5;
  localparam logic [15:0] HDR_LEN_HI    = 16'd6;
  localparam logic [15:0] HDR_CRC_LO    = 16'd7;
  localparam logic [15:0] HDR_LAST_POS  = 16'(HEADER_BYTES - 1);
  localparam logic [15:0] TAIL_LEN      = 16'(TAIL_BYTES);

  localparam logic [15:0] CRC_POLY           = 16'h1021;
  localparam logic [15:0] DEFAULT_MAX_LENGTH = 16'd1500;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TAIL    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PAYLOAD    = 3'd1,
    EV_FRAME_GOOD = 3'd2,
    EV_BAD_LENGTH = 3'd3,
    EV_BAD_TAIL   = 3'd4,
    EV_BAD_CRC    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    CFG_HEAD_WORD  = 2'd0,
    CFG_TAIL_WORD  = 2'd1,
    CFG_MAX_LENGTH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] head_word;
    logic [31:0] tail_word;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] head_window;
    logic [15:0] byte_index;
    logic [31:0] header_frame_number;
    logic [7:0]  header_type;
    logic [15:0] header_length;
    logic [15:0] header_crc;
    logic [15:0] running_crc;
    logic [31:0] tail_window;
    logic [31:0] previous_frame_number;
    logic [31:0] lost_count;
    logic [31:0] wrong_count;
  } state_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } result_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* design/fdc_cfg_regs.sv */
// Configuration registers of the frame deframer: head word, tail word, max length.
// Depends on fdc_pkg.
module fdc_cfg_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [1:0]              wr_index,
  input  logic [31:0]             wr_data,
  output fdc_pkg::cfg_t           cfg
);
  import fdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_word  <= '0;
      cfg.tail_word  <= '0;
      cfg.max_length <= DEFAULT_MAX_LENGTH;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_HEAD_WORD:  cfg.head_word  <= wr_data;
        CFG_TAIL_WORD:  cfg.tail_word  <= wr_data;
        CFG_MAX_LENGTH: cfg.max_length <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/fdc_step.sv */
// Per-byte deframer logic: next state and result for one received byte.
// Purely combinational; depends on fdc_pkg.
module fdc_step (
  input  fdc_pkg::state_t  st,
  input  fdc_pkg::cfg_t    cfg,
  input  logic [7:0]       rx_byte,
  output fdc_pkg::state_t  st_next,
  output fdc_pkg::result_t res
);
  import fdc_pkg::*;

  logic [31:0] head_shift;
  logic [31:0] tail_shift;
  logic [15:0] idx_inc;
  logic [31:0] frame_gap;
  logic [31:0] lost_after_hdr;
  logic        gap_valid;

  assign head_shift = {rx_byte, st.head_window[31:8]};
  assign tail_shift = {rx_byte, st.tail_window[31:8]};
  assign idx_inc    = st.byte_index + 16'd1;

  // The frame number is complete before the last header byte arrives.
  assign gap_valid      = (st.header_frame_number > st.previous_frame_number) &&
                          (st.previous_frame_number != 32'd0);
  assign frame_gap      = st.header_frame_number - st.previous_frame_number - 32'd1;
  assign lost_after_hdr = gap_valid ? (st.lost_count + frame_gap) : st.lost_count;

  always_comb begin
    st_next           = st;
    res.ev            = EV_NONE;
    res.payload_byte  = '0;
    res.payload_index = '0;
    unique case (st.phase)
      PH_HUNT: begin
        st_next.head_window = head_shift;
        if (head_shift == cfg.head_word) begin
          st_next.phase      = PH_HEADER;
          st_next.byte_index = '0;
        end
      end
      PH_HEADER: begin
        priority if (st.byte_index < HDR_TYPE_POS) begin
          st_next.header_frame_number[8*st.byte_index[1:0] +: 8] = rx_byte;
        end else if (st.byte_index == HDR_TYPE_POS) begin
          st_next.header_type = rx_byte;
        end else if (st.byte_index == HDR_LEN_LO) begin
          st_next.header_length[7:0] = rx_byte;
        end else if (st.byte_index == HDR_LEN_HI) begin
          st_next.header_length[15:8] = rx_byte;
        end else if (st.byte_index == HDR_CRC_LO) begin
          st_next.header_crc[7:0] = rx_byte;
        end else begin
          st_next.header_crc[15:8] = rx_byte;
        end
        if (st.byte_index >= HDR_LAST_POS) begin
          st_next.byte_index            = '0;
          st_next.previous_frame_number = st.header_frame_number;
          st_next.lost_count            = lost_after_hdr;
          if (st.header_length == 16'd0 || st.header_length > cfg.max_length) begin
            st_next.phase       = PH_HUNT;
            st_next.lost_count  = lost_after_hdr + 32'd1;
            st_next.wrong_count = st.wrong_count + 32'd1;
            res.ev              = EV_BAD_LENGTH;
          end else begin
            st_next.phase       = PH_PAYLOAD;
            st_next.running_crc = '0;
          end
        end else begin
          st_next.byte_index = idx_inc;
        end
      end
      PH_PAYLOAD: begin
        res.ev              = EV_PAYLOAD;
        res.payload_byte    = rx_byte;
        res.payload_index   = st.byte_index;
        st_next.running_crc = crc16_byte(st.running_crc, rx_byte);
        st_next.byte_index  = idx_inc;
        if (idx_inc == st.header_length) begin
          st_next.phase      = PH_TAIL;
          st_next.byte_index = '0;
        end
      end
      PH_TAIL: begin
        st_next.tail_window = tail_shift;
        st_next.byte_index  = idx_inc;
        if (idx_inc >= TAIL_LEN) begin
          st_next.byte_index = '0;
          st_next.phase      = PH_HUNT;
          // A bad tail takes precedence over a bad CRC.
          priority if (tail_shift != cfg.tail_word) begin
            st_next.lost_count  = st.lost_count + 32'd1;
            st_next.wrong_count = st.wrong_count + 32'd1;
            res.ev              = EV_BAD_TAIL;
          end else if (st.running_crc != st.header_crc) begin
            st_next.lost_count  = st.lost_count + 32'd1;
            st_next.wrong_count = st.wrong_count + 32'd1;
            res.ev              = EV_BAD_CRC;
          end else begin
            res.ev = EV_FRAME_GOOD;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/frame_deframer_crc16_check_unit.sv */
// Top level of the framed packet receiver with CRC-16/XMODEM check.
// Depends on fdc_pkg, fdc_cfg_regs and fdc_step.
//
// The block takes one received byte per cycle unless the output stalls, and returns exactly one
// result per byte. A byte goes into an input register; when the output register is free, the
// deframer state and the result register are updated together from it. A new byte can be
// taken every cycle as long as results are taken. The longest path is the one-byte CRC step in
// the payload phase, together with the 32-bit lost-frame arithmetic at header end. The head,
// tail and max length registers may be written only while no byte is in flight.
module frame_deframer_crc16_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  packet_type,
  output logic [31:0] frame_number,
  output logic [31:0] lost_total,
  output logic [31:0] wrong_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fdc_pkg::*;

  cfg_t        cfg;
  state_t      st;
  state_t      st_next;
  result_t     res;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        advance;
  logic        fire;

  assign cfg_ready = 1'b1;

  fdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fdc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .rx_byte (s1_byte),
    .st_next (st_next),
    .res     (res)
  );

  // The output register frees up when it is empty or its result transfers this cycle.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (fire) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res     <= res.ev;
      payload_byte  <= res.payload_byte;
      payload_index <= res.payload_index;
      packet_type   <= st_next.header_type;
      frame_number  <= st_next.header_frame_number;
      lost_total    <= st_next.lost_count;
      wrong_total   <= st_next.wrong_count;
    end
  end

`ifndef SYNTHESIS
  a_payload_index_in_range: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_PAYLOAD |-> st.byte_index < st.header_length)
    else $error("payload byte index reached the frame length");

  a_tail_index_in_range: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_TAIL |-> st.byte_index < TAIL_LEN)
    else $error("tail byte index out of range");

  a_reject_counts_once: assert property (@(posedge clk) disable iff (rst)
    (fire && (res.ev == EV_BAD_LENGTH || res.ev == EV_BAD_TAIL || res.ev == EV_BAD_CRC))
    |=> st.wrong_count == $past(st.wrong_count) + 32'd1)
    else $error("rejected frame did not add one to the wrong frame count");

  a_result_follows_fire: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed byte produced no result");
`endif

endmodule
